// File: sv/multichannel_oneshot_continuous_timer_defines.svh
// Assertion macros shared by the checker of the timer bank.
// No dependencies; the checker file includes this header.
`ifndef MULTICHANNEL_ONESHOT_CONTINUOUS_TIMER_DEFINES_SVH
`define MULTICHANNEL_ONESHOT_CONTINUOUS_TIMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MCOT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MCOT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mcot_pkg.sv
// Types and codes for the multichannel one-shot / continuous timer bank.
// No dependencies; used by the channel bank and the top level.
package mcot_pkg;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_START    = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_NTF_ON   = 3'd3,
    ACT_NTF_OFF  = 3'd4,
    ACT_READ_EL  = 3'd5,
    ACT_READ_REM = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_CHANNEL = 2'd1,
    ERR_VALUE   = 2'd2,
    ERR_BUSY    = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_INIT    = 2'd0,
    ST_RUN     = 2'd1,
    ST_STOP    = 2'd2,
    ST_EXPIRED = 2'd3
  } chan_st_t;

  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_ONESHOT_MASK  = 2'd1;
  localparam logic [1:0] REG_NOTIFY_MASK   = 2'd2;
  localparam logic [1:0] REG_VALUE_MAX     = 2'd3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  channel;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [3:0]  channel_count;
    logic [7:0]  oneshot_mask;
    logic [7:0]  notify_present_mask;
    logic [31:0] value_max;
  } cfg_t;

  typedef struct packed {
    logic [31:0] read_value;
    err_t        error_code;
    logic        notify_pulse;
    chan_st_t    channel_state;
  } rsp_t;

endpackage

// File: sv/mcot_chan_bank.sv
// Per-channel timer state and the single-pass step logic for one beat.
// Depends on mcot_pkg.
module mcot_chan_bank #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  mcot_pkg::req_t req,
  input  mcot_pkg::cfg_t cfg,
  output mcot_pkg::rsp_t rsp
);
  import mcot_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  chan_st_t    st_r  [NUM_CHANNELS];
  logic        ntf_r [NUM_CHANNELS];
  logic [31:0] tgt_r [NUM_CHANNELS];
  logic [31:0] el_r  [NUM_CHANNELS];

  logic [IDX_W-1:0] idx;
  logic             ch_ok;
  logic             os_bit;
  logic             np_bit;
  chan_st_t         cur_st;
  logic             cur_ntf;
  logic [31:0]      cur_tgt;
  logic [31:0]      cur_el;
  logic [31:0]      el_inc;
  chan_st_t         st_nxt;
  logic             ntf_nxt;
  logic [31:0]      tgt_nxt;
  logic [31:0]      el_nxt;
  logic [31:0]      rd;
  err_t             err;
  logic             pulse;
  logic             wr_en;

  always_comb begin
    idx     = req.channel[IDX_W-1:0];
    ch_ok   = ({1'b0, req.channel} < 5'(NUM_CHANNELS)) && (req.channel < cfg.channel_count);
    // masks only cover the first eight channels
    os_bit  = !req.channel[3] && cfg.oneshot_mask[req.channel[2:0]];
    np_bit  = !req.channel[3] && cfg.notify_present_mask[req.channel[2:0]];
    cur_st  = st_r[idx];
    cur_ntf = ntf_r[idx];
    cur_tgt = tgt_r[idx];
    cur_el  = el_r[idx];
    el_inc  = cur_el + 32'd1;
    st_nxt  = cur_st;
    ntf_nxt = cur_ntf;
    tgt_nxt = cur_tgt;
    el_nxt  = cur_el;
    rd      = '0;
    err     = ERR_OK;
    pulse   = 1'b0;
    if (!ch_ok) begin
      err = ERR_CHANNEL;
    end else begin
      case (action_t'(req.action))
        ACT_TICK: begin
          if (cur_st == ST_RUN) begin
            el_nxt = el_inc;
            if (el_inc >= cur_tgt) begin
              if (os_bit) begin
                st_nxt = ST_EXPIRED;
              end else begin
                el_nxt = '0;
              end
              pulse = cur_ntf && np_bit;
            end
          end
        end
        ACT_START: begin
          if (req.value == 32'd0 || req.value > cfg.value_max) begin
            err = ERR_VALUE;
          end else if (cur_st == ST_RUN) begin
            err = ERR_BUSY;
          end else begin
            tgt_nxt = req.value;
            el_nxt  = '0;
            st_nxt  = ST_RUN;
          end
        end
        ACT_STOP: begin
          if (cur_st == ST_RUN) begin
            st_nxt = ST_STOP;
          end
        end
        ACT_NTF_ON, ACT_NTF_OFF: begin
          if (!np_bit) begin
            err = ERR_CHANNEL;
          end else begin
            ntf_nxt = (action_t'(req.action) == ACT_NTF_ON);
          end
        end
        ACT_READ_EL: begin
          rd = cur_el;
        end
        ACT_READ_REM: begin
          rd = cur_tgt - cur_el;
        end
        default: begin
        end
      endcase
    end
    wr_en             = step && ch_ok;
    rsp.read_value    = rd;
    rsp.error_code    = err;
    rsp.notify_pulse  = pulse;
    rsp.channel_state = ch_ok ? st_nxt : ST_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        st_r[i]  <= ST_INIT;
        ntf_r[i] <= 1'b0;
        tgt_r[i] <= '0;
        el_r[i]  <= '0;
      end
    end else if (wr_en) begin
      st_r[idx]  <= st_nxt;
      ntf_r[idx] <= ntf_nxt;
      tgt_r[idx] <= tgt_nxt;
      el_r[idx]  <= el_nxt;
    end
  end

endmodule

// File: sv/multichannel_oneshot_continuous_timer.sv
// Multichannel one-shot / continuous timer bank: top level.
// Holds the configuration registers, the input register and the result register.
// Channels: in_* carries one action beat (action, channel, target value);
// out_* returns exactly one result beat per input beat, in order.
// cfg_* writes one register per cycle: 0 channel_count, 1 oneshot_mask,
// 2 notify_present_mask, 3 value_max. Write only while the bank is idle.
// Each beat is taken into an input register; the channel's state is read,
// stepped and written back in the same cycle as the result register is loaded.
// Beats pass the input register, then the result register. Throughput: one
// beat per cycle unless out stalls, set by the single per-channel read-modify-write.
// Back-to-back beats on the same channel see each other's updates.
// Reset: all channels initialised with count, target and notify cleared;
// channel_count 8, both masks 0, value_max all ones; no beat in flight.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat, then in_tready drops until out_tready returns.
module multichannel_oneshot_continuous_timer #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [2:0] action, [6:3] channel, [38:7] value, [39] zero
  input  logic [mcot_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] read_value, [33:32] error_code, [34] notify_pulse,
  // [36:35] channel_state, [39:37] zero
  output logic [mcot_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_we,
  input  logic [mcot_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mcot_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import mcot_pkg::*;

  cfg_t cfg_r;
  logic s1_valid_r;
  logic s1_valid_nxt;
  req_t s1_req_r;
  logic out_valid_r;
  logic out_valid_nxt;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic adv;
  logic in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count       <= 4'd8;
      cfg_r.oneshot_mask        <= '0;
      cfg_r.notify_present_mask <= '0;
      cfg_r.value_max           <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CHANNEL_COUNT: cfg_r.channel_count       <= cfg_wdata[3:0];
        REG_ONESHOT_MASK:  cfg_r.oneshot_mask        <= cfg_wdata[7:0];
        REG_NOTIFY_MASK:   cfg_r.notify_present_mask <= cfg_wdata[7:0];
        REG_VALUE_MAX:     cfg_r.value_max           <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // advance the held beat whenever the result register is free or draining
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !adv);
    out_valid_nxt = adv || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.action  <= in_tdata[2:0];
      s1_req_r.channel <= in_tdata[6:3];
      s1_req_r.value   <= in_tdata[38:7];
    end
    if (adv) begin
      out_rsp_r <= rsp;
    end
  end

  mcot_chan_bank #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .req   (s1_req_r),
    .cfg   (cfg_r),
    .rsp   (rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_rsp_r.channel_state, out_rsp_r.notify_pulse,
                       out_rsp_r.error_code, out_rsp_r.read_value};

endmodule

// File: sv/mcot_checker.sv
// Port-level checks on the result channel of the timer bank, bound to the top level.
// Depends on mcot_pkg and the assertion macros header.
`include "multichannel_oneshot_continuous_timer_defines.svh"

module mcot_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mcot_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mcot_pkg::*;

  logic [31:0] rd_f;
  err_t        err_f;
  logic        pulse_f;
  chan_st_t    st_f;
  logic        stall;
  logic        pulse_ok;
  logic        err_quiet;

  // unpack the result beat
  assign rd_f      = out_tdata[31:0];
  assign err_f     = err_t'(out_tdata[33:32]);
  assign pulse_f   = out_tdata[34];
  assign st_f      = chan_st_t'(out_tdata[36:35]);
  assign stall     = out_tvalid && !out_tready;
  assign pulse_ok  = (err_f == ERR_OK) && (st_f == ST_RUN || st_f == ST_EXPIRED);
  assign err_quiet = (rd_f == 32'd0) && !pulse_f;

  `MCOT_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_tvalid, "result beat dropped in stall")
  `MCOT_ASSERT_NEXT(a_out_stable, clk, rst_n, stall, $stable(out_tdata), "result beat changed")
  `MCOT_ASSERT_NOW(a_pulse_ok, clk, rst_n, out_tvalid && pulse_f, pulse_ok, "bad notify pulse")
  `MCOT_ASSERT_NOW(a_err_quiet, clk, rst_n, out_tvalid && err_f != ERR_OK, err_quiet, "noisy error")

endmodule

bind multichannel_oneshot_continuous_timer mcot_checker u_mcot_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the multichannel one-shot / continuous timer bank.
// Needs mcot_pkg and multichannel_oneshot_continuous_timer; a built-in
// predictor checks every result beat against its own copy of the channel state.
module tb_top;
  import mcot_pkg::*;

  localparam int NCH = 8;
  localparam int IDLE_PCT = 22;
  localparam int STALL_LIMIT = 1000;
  localparam logic [2:0] ACT_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // mirror of the register file
  logic [3:0] m_count;
  logic [7:0] m_oneshot;
  logic [7:0] m_notify;
  logic [31:0] m_vmax;

  // per-channel timer state as the block should hold it
  chan_st_t run_state[NCH];
  logic notify_on[NCH];
  logic [31:0] target[NCH];
  logic [31:0] elapsed[NCH];

  req_t pending[$];
  rsp_t result_due[$];
  req_t bus_req;
  rsp_t want;
  logic calm = 1'b0;
  int unsigned stuck = 0;
  int unsigned n_bad = 0;

  multichannel_oneshot_continuous_timer #(
    .NUM_CHANNELS(NCH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Advance the timer bank by one action and return the result it owes.
  function automatic rsp_t timer_step(req_t r);
    rsp_t o;
    logic [3:0] c;
    c = r.channel;
    o = '0;
    if (c >= m_count || c >= NCH) begin
      o.error_code = ERR_CHANNEL;
    end else begin
      case (r.action)
        ACT_TICK: begin
          if (run_state[c] == ST_RUN) begin
            elapsed[c] = elapsed[c] + 32'd1;
            if (elapsed[c] >= target[c]) begin
              if (m_oneshot[c]) run_state[c] = ST_EXPIRED;
              else elapsed[c] = '0;
              if (notify_on[c] && m_notify[c]) o.notify_pulse = 1'b1;
            end
          end
        end
        ACT_START: begin
          if (r.value == '0 || r.value > m_vmax) begin
            o.error_code = ERR_VALUE;
          end else if (run_state[c] == ST_RUN) begin
            o.error_code = ERR_BUSY;
          end else begin
            target[c] = r.value;
            elapsed[c] = '0;
            run_state[c] = ST_RUN;
          end
        end
        ACT_STOP: begin
          if (run_state[c] == ST_RUN) run_state[c] = ST_STOP;
        end
        ACT_NTF_ON, ACT_NTF_OFF: begin
          if (!m_notify[c]) o.error_code = ERR_CHANNEL;
          else notify_on[c] = (r.action == ACT_NTF_ON);
        end
        ACT_READ_EL: o.read_value = elapsed[c];
        ACT_READ_REM: o.read_value = target[c] - elapsed[c];
        default: ;
      endcase
      o.channel_state = run_state[c];
    end
    return o;
  endfunction

  function automatic void queue_req(logic [2:0] act, logic [3:0] ch, logic [31:0] val);
    req_t r;
    r.action = act;
    r.channel = ch;
    r.value = val;
    pending.push_back(r);
  endfunction

  // Mostly well-formed traffic with a favoured channel so that counts reach their target.
  function automatic req_t random_req(logic [3:0] hot);
    req_t r;
    int unsigned p;
    int unsigned q;
    p = $urandom_range(99);
    if (p < 45) r.action = ACT_TICK;
    else if (p < 60) r.action = ACT_START;
    else if (p < 67) r.action = ACT_STOP;
    else if (p < 72) r.action = ACT_NTF_ON;
    else if (p < 76) r.action = ACT_NTF_OFF;
    else if (p < 85) r.action = ACT_READ_EL;
    else if (p < 94) r.action = ACT_READ_REM;
    else if (p < 97) r.action = ACT_SPARE;
    else r.action = 3'($urandom_range(7));
    p = $urandom_range(99);
    if (p < 50) r.channel = hot;
    else if (p < 92) r.channel = 4'($urandom_range(NCH - 1));
    else r.channel = 4'($urandom_range(15));
    q = $urandom_range(99);
    if (q < 70) r.value = $urandom_range(6, 1);
    else if (q < 80) r.value = m_vmax;
    else if (q < 85) r.value = '0;
    else if (q < 90) r.value = m_vmax + 32'd1;
    else r.value = $urandom;
    return r;
  endfunction

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_v);
    n_bad++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= d;
    case (idx)
      REG_CHANNEL_COUNT: m_count = d[3:0];
      REG_ONESHOT_MASK: m_oneshot = d[7:0];
      REG_NOTIFY_MASK: m_notify = d[7:0];
      REG_VALUE_MAX: m_vmax = d;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [3:0] cnt, input logic [7:0] os,
                              input logic [7:0] np, input logic [31:0] vmax);
    write_reg(REG_CHANNEL_COUNT, {28'd0, cnt});
    write_reg(REG_ONESHOT_MASK, {24'd0, os});
    write_reg(REG_NOTIFY_MASK, {24'd0, np});
    write_reg(REG_VALUE_MAX, vmax);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every queued beat has gone in and every result has come back.
  task automatic settle();
    @(negedge clk);
    while (pending.size() != 0 || in_tvalid || result_due.size() != 0) @(negedge clk);
  endtask

  // input driver: predict on acceptance, then offer the next beat or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) result_due.push_back(timer_step(bus_req));
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          bus_req = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, bus_req.value, bus_req.channel, bus_req.action};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_due.size() == 0) begin
          flag("unexpected beat", out_tdata[31:0], '0);
        end else begin
          want = result_due.pop_front();
          if (out_tdata[31:0] !== want.read_value)
            flag("read_value", out_tdata[31:0], want.read_value);
          if (out_tdata[33:32] !== want.error_code)
            flag("error_code", 32'(out_tdata[33:32]), 32'(want.error_code));
          if (out_tdata[34] !== want.notify_pulse)
            flag("notify_pulse", 32'(out_tdata[34]), 32'(want.notify_pulse));
          if (out_tdata[36:35] !== want.channel_state)
            flag("channel_state", 32'(out_tdata[36:35]), 32'(want.channel_state));
        end
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stuck <= 0;
      end else if (stuck >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  initial begin
    logic [3:0] hot;
    int unsigned p;
    logic [3:0] cnt;
    logic [7:0] np;
    logic [31:0] vmax;
    m_count = 4'd8;
    m_oneshot = '0;
    m_notify = '0;
    m_vmax = '1;
    for (int i = 0; i < NCH; i++) begin
      run_state[i] = ST_INIT;
      notify_on[i] = 1'b0;
      target[i] = '0;
      elapsed[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle reads, rejects, full-range target
    @(negedge clk);
    queue_req(ACT_READ_EL, 4'd0, 32'd0);
    queue_req(ACT_READ_REM, 4'd0, 32'hFFFF_FFFF);
    queue_req(ACT_TICK, 4'd0, 32'd0);
    queue_req(ACT_START, 4'd0, 32'd0);
    queue_req(ACT_STOP, 4'd1, 32'd0);
    queue_req(ACT_NTF_ON, 4'd0, 32'd0);
    queue_req(ACT_SPARE, 4'd2, 32'd0);
    queue_req(ACT_START, 4'd8, 32'd5);
    queue_req(ACT_TICK, 4'd15, 32'd0);
    queue_req(ACT_START, 4'd7, 32'hFFFF_FFFF);
    queue_req(ACT_START, 4'd7, 32'd3);
    queue_req(ACT_TICK, 4'd7, 32'd0);
    queue_req(ACT_READ_REM, 4'd7, 32'd0);
    queue_req(ACT_STOP, 4'd7, 32'd0);
    queue_req(ACT_START, 4'd7, 32'd1);
    queue_req(ACT_TICK, 4'd7, 32'd0);
    settle();

    // few channels, one-shot expiry with notification, hidden channel
    program_regs(4'd3, 8'h04, 8'h05, 32'd10);
    queue_req(ACT_START, 4'd0, 32'd11);
    queue_req(ACT_START, 4'd2, 32'd2);
    queue_req(ACT_NTF_ON, 4'd2, 32'd0);
    queue_req(ACT_TICK, 4'd2, 32'd0);
    queue_req(ACT_TICK, 4'd2, 32'd0);
    queue_req(ACT_READ_REM, 4'd2, 32'd0);
    queue_req(ACT_NTF_ON, 4'd1, 32'd0);
    queue_req(ACT_READ_EL, 4'd7, 32'd0);
    settle();

    program_regs(4'd0, 8'hFF, 8'hFF, 32'd1);
    queue_req(ACT_TICK, 4'd0, 32'd0);
    settle();

    program_regs(4'd8, 8'hFF, 8'hFF, 32'd1);
    queue_req(ACT_START, 4'd3, 32'd2);
    queue_req(ACT_START, 4'd3, 32'd1);
    queue_req(ACT_TICK, 4'd3, 32'd0);
    settle();

    // random phases, each under fresh settings
    for (int ph = 0; ph < 8; ph++) begin
      p = $urandom_range(99);
      cnt = (p < 60) ? 4'd8 : 4'($urandom_range(8));
      p = $urandom_range(99);
      np = (p < 40) ? 8'hFF : 8'($urandom_range(255));
      p = $urandom_range(99);
      if (p < 40) vmax = '1;
      else if (p < 70) vmax = $urandom_range(8, 1);
      else vmax = $urandom_range(32'hFFFF_FFFF, 1);
      program_regs(cnt, 8'($urandom_range(255)), np, vmax);
      calm = (ph == 3);
      hot = 4'($urandom_range(NCH - 1));
      for (int k = 0; k < 100; k++) pending.push_back(random_req(hot));
      settle();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk);
    if (result_due.size() != 0) flag("results never delivered", 32'(result_due.size()), '0);
    if (n_bad == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: multichannel_oneshot_continuous_timer.f
+incdir+sv
sv/mcot_pkg.sv
sv/mcot_chan_bank.sv
sv/multichannel_oneshot_continuous_timer.sv
sv/mcot_checker.sv
dv/tb_top.sv
